@@ rtl/jst_pkg.sv @@
// Shared types, codes and constants of the JSON subset tokenizer.
`default_nettype none

package jst_pkg;

    // Field widths of the request and result channels.
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 5;
    localparam int DEPTH_W = 6;
    localparam int ERR_W   = 2;

    // Default limit on object nesting.
    localparam int MAX_NEST_DEPTH_DEF = 32;

    // Characters the grammar knows.
    localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5D;
    localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;

    // Token kinds reported with each byte.
    typedef enum logic [KIND_W-1:0] {
        TK_SKIP        = 5'd0,
        TK_OBJ_OPEN    = 5'd1,
        TK_KEY_QUOTE   = 5'd2,
        TK_KEY_CHAR    = 5'd3,
        TK_KEY_END     = 5'd4,
        TK_COLON       = 5'd5,
        TK_VAL_QUOTE   = 5'd6,
        TK_VAL_CHAR    = 5'd7,
        TK_VAL_END     = 5'd8,
        TK_LIST_OPEN   = 5'd9,
        TK_ITEM_QUOTE  = 5'd10,
        TK_ITEM_CHAR   = 5'd11,
        TK_ITEM_END    = 5'd12,
        TK_ITEM_COMMA  = 5'd13,
        TK_LIST_CLOSE  = 5'd14,
        TK_MEMB_COMMA  = 5'd15,
        TK_OBJ_CLOSE   = 5'd16
    } tok_kind_t;

    // Error codes, sticky within a document.
    typedef enum logic [ERR_W-1:0] {
        ERR_NONE   = 2'd0,
        ERR_FORMAT = 2'd1,
        ERR_DEPTH  = 2'd2
    } err_code_t;

    // Parser states.
    typedef enum logic [3:0] {
        PS_OPEN       = 4'd0,
        PS_KEY_OR_END = 4'd1,
        PS_SEEK_KEY   = 4'd2,
        PS_IN_KEY     = 4'd3,
        PS_COLON      = 4'd4,
        PS_VALUE      = 4'd5,
        PS_ITEM_Q     = 4'd6,
        PS_IN_STR     = 4'd7,
        PS_ITEM_SEP   = 4'd8,
        PS_MEMB_SEP   = 4'd9,
        PS_CLOSED     = 4'd10
    } parse_state_t;

    // Complete scanner state carried from byte to byte.
    typedef struct packed {
        parse_state_t        ps;
        logic [DEPTH_W-1:0]  nest;
        logic                in_list;
        err_code_t           err;
    } scan_state_t;

    localparam scan_state_t SCAN_RESET = '{
        ps:      PS_OPEN,
        nest:    '0,
        in_list: 1'b0,
        err:     ERR_NONE
    };

endpackage

`default_nettype wire

@@ rtl/jst_if.sv @@
// Request and result channel interfaces of the JSON subset tokenizer.
`default_nettype none

interface jst_in_if
    import jst_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_doc;

    modport source (output valid, output data_byte, output end_of_doc, input ready);
    modport sink   (input valid, input data_byte, input end_of_doc, output ready);
endinterface

interface jst_out_if
    import jst_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [BYTE_W-1:0]  byte_out;
    logic [KIND_W-1:0]  token_kind;
    logic [DEPTH_W-1:0] nest_depth;
    logic [ERR_W-1:0]   error_code;
    logic               doc_done;
    logic               doc_ok;

    modport source (
        output valid, output byte_out, output token_kind, output nest_depth,
        output error_code, output doc_done, output doc_ok, input ready
    );
    modport sink (
        input valid, input byte_out, input token_kind, input nest_depth,
        input error_code, input doc_done, input doc_ok, output ready
    );
endinterface

`default_nettype wire

@@ rtl/jst_step.sv @@
// Next-state and token-kind logic for one byte of the tokenizer.
`default_nettype none

module jst_step
    import jst_pkg::*;
#(
    parameter int MAX_NEST_DEPTH = MAX_NEST_DEPTH_DEF
) (
    input  scan_state_t       cur,
    input  logic [BYTE_W-1:0] data,
    output scan_state_t       nxt,
    output tok_kind_t         kind
);

    localparam logic [DEPTH_W-1:0] DepthLimit = DEPTH_W'(MAX_NEST_DEPTH);

    logic blank;
    logic fail;

    assign blank = (data == CH_TAB) || (data == CH_LF) || (data == CH_CR) ||
                   (data == CH_SPACE);

    // One transition of the parser; errors freeze the state until the end.
    always_comb
    begin
        nxt  = cur;
        kind = TK_SKIP;
        fail = 1'b0;
        if (cur.err == ERR_NONE && !blank)
        begin
            unique case (cur.ps)
                PS_OPEN:
                begin
                    if (data == CH_LBRACE)
                    begin
                        nxt.ps = PS_KEY_OR_END;
                        kind   = TK_OBJ_OPEN;
                    end
                    else
                    begin
                        fail = 1'b1;
                    end
                end
                PS_KEY_OR_END, PS_MEMB_SEP:
                begin
                    if (data == CH_QUOTE && cur.ps == PS_KEY_OR_END)
                    begin
                        nxt.ps = PS_IN_KEY;
                        kind   = TK_KEY_QUOTE;
                    end
                    else if (data == CH_COMMA && cur.ps == PS_MEMB_SEP)
                    begin
                        nxt.ps = PS_SEEK_KEY;
                        kind   = TK_MEMB_COMMA;
                    end
                    else if (data == CH_RBRACE)
                    begin
                        // Closing the outermost object ends the document body.
                        if (cur.nest == '0)
                        begin
                            nxt.ps = PS_CLOSED;
                        end
                        else
                        begin
                            nxt.nest = cur.nest - 1'b1;
                            nxt.ps   = PS_MEMB_SEP;
                        end
                        kind = TK_OBJ_CLOSE;
                    end
                    else
                    begin
                        fail = 1'b1;
                    end
                end
                PS_SEEK_KEY:
                begin
                    // Anything before the next key quote is ignored.
                    if (data == CH_QUOTE)
                    begin
                        nxt.ps = PS_IN_KEY;
                        kind   = TK_KEY_QUOTE;
                    end
                end
                PS_IN_KEY:
                begin
                    if (data == CH_QUOTE)
                    begin
                        nxt.ps = PS_COLON;
                        kind   = TK_KEY_END;
                    end
                    else
                    begin
                        kind = TK_KEY_CHAR;
                    end
                end
                PS_COLON:
                begin
                    if (data == CH_COLON)
                    begin
                        nxt.ps = PS_VALUE;
                        kind   = TK_COLON;
                    end
                    else
                    begin
                        fail = 1'b1;
                    end
                end
                PS_VALUE:
                begin
                    if (data == CH_QUOTE)
                    begin
                        nxt.ps = PS_IN_STR;
                        kind   = TK_VAL_QUOTE;
                    end
                    else if (data == CH_LBRACK)
                    begin
                        nxt.in_list = 1'b1;
                        nxt.ps      = PS_ITEM_Q;
                        kind        = TK_LIST_OPEN;
                    end
                    else if (data == CH_LBRACE)
                    begin
                        // A nested object beyond the limit is a depth error.
                        if (cur.nest >= DepthLimit)
                        begin
                            nxt.err = ERR_DEPTH;
                        end
                        else
                        begin
                            nxt.nest = cur.nest + 1'b1;
                            nxt.ps   = PS_KEY_OR_END;
                            kind     = TK_OBJ_OPEN;
                        end
                    end
                    else
                    begin
                        fail = 1'b1;
                    end
                end
                PS_ITEM_Q:
                begin
                    if (data == CH_QUOTE)
                    begin
                        nxt.ps = PS_IN_STR;
                        kind   = TK_ITEM_QUOTE;
                    end
                    else
                    begin
                        fail = 1'b1;
                    end
                end
                PS_IN_STR:
                begin
                    if (cur.in_list)
                    begin
                        if (data == CH_QUOTE)
                        begin
                            nxt.ps = PS_ITEM_SEP;
                            kind   = TK_ITEM_END;
                        end
                        else
                        begin
                            kind = TK_ITEM_CHAR;
                        end
                    end
                    else if (data == CH_QUOTE)
                    begin
                        nxt.ps = PS_MEMB_SEP;
                        kind   = TK_VAL_END;
                    end
                    else
                    begin
                        kind = TK_VAL_CHAR;
                    end
                end
                PS_ITEM_SEP:
                begin
                    if (data == CH_COMMA)
                    begin
                        nxt.ps = PS_ITEM_Q;
                        kind   = TK_ITEM_COMMA;
                    end
                    else if (data == CH_RBRACK)
                    begin
                        nxt.in_list = 1'b0;
                        nxt.ps      = PS_MEMB_SEP;
                        kind        = TK_LIST_CLOSE;
                    end
                    else
                    begin
                        fail = 1'b1;
                    end
                end
                default:
                begin
                    // The closed state and unused codes accept nothing.
                    fail = 1'b1;
                end
            endcase
            if (fail)
            begin
                nxt      = cur;
                nxt.err  = ERR_FORMAT;
                kind     = TK_SKIP;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/json_subset_tokenizer.sv @@
// JSON subset tokenizer: byte-at-a-time parser with one result per byte.
//
// Channels: din carries one raw byte per request (data_byte) with end_of_doc
// on the last byte of a document; dout returns one result per byte: the byte
// echoed, its token kind, the object nesting depth after it, the sticky error
// code, and on the last byte doc_done with doc_ok.
// Path: an accepted byte is registered in the input stage, passes the parser
// logic, and then is registered in the result register that drives dout.
// Throughput: one byte per cycle, sustained while dout takes each result. The
// parser state is updated together with the result register.
// Stalls: while dout is held, one more byte waits in the input stage; din
// drops ready only when both the input stage and the result are full.
// Reset: rst_n clears both stages and returns the parser to waiting for the
// opening brace. The last byte of each document restores that parser state
// after its result is formed, so the next byte starts a fresh document.
`default_nettype none

module json_subset_tokenizer
    import jst_pkg::*;
#(
    parameter int MAX_NEST_DEPTH = MAX_NEST_DEPTH_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    jst_in_if.sink     din,
    jst_out_if.source  dout
);

    // Input stage.
    logic              s1_valid_reg;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              s1_last_reg;

    // Result register.
    logic               out_valid_reg;
    logic [BYTE_W-1:0]  out_byte_reg;
    tok_kind_t          out_kind_reg;
    logic [DEPTH_W-1:0] out_depth_reg;
    err_code_t          out_err_reg;
    logic               out_done_reg;
    logic               out_ok_reg;

    // Parser state.
    scan_state_t state_reg;
    scan_state_t state_next;
    tok_kind_t   step_kind;

    logic advance;
    logic s1_load;

    jst_step #(
        .MAX_NEST_DEPTH (MAX_NEST_DEPTH)
    ) u_step (
        .cur  (state_reg),
        .data (s1_byte_reg),
        .nxt  (state_next),
        .kind (step_kind)
    );

    // The staged byte moves on whenever the result register is free.
    assign advance = s1_valid_reg && (!out_valid_reg || dout.ready);
    assign din.ready = !s1_valid_reg || advance;
    assign s1_load = din.valid && din.ready;

    // Input stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (din.ready)
        begin
            s1_valid_reg <= din.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_byte_reg <= din.data_byte;
            s1_last_reg <= din.end_of_doc;
        end
    end

    // Parser state; the last byte of a document restores the reset state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SCAN_RESET;
        end
        else if (advance)
        begin
            state_reg <= s1_last_reg ? SCAN_RESET : state_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (dout.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg  <= s1_byte_reg;
            out_kind_reg  <= step_kind;
            out_depth_reg <= state_next.nest;
            out_err_reg   <= state_next.err;
            out_done_reg  <= s1_last_reg;
            out_ok_reg    <= s1_last_reg && (state_next.ps == PS_CLOSED) &&
                             (state_next.err == ERR_NONE);
        end
    end

    assign dout.valid      = out_valid_reg;
    assign dout.byte_out   = out_byte_reg;
    assign dout.token_kind = out_kind_reg;
    assign dout.nest_depth = out_depth_reg;
    assign dout.error_code = out_err_reg;
    assign dout.doc_done   = out_done_reg;
    assign dout.doc_ok     = out_ok_reg;

endmodule

`default_nettype wire

@@ rtl/jst_checker.sv @@
// Port-level checks of the JSON subset tokenizer, bound to the top level.
`default_nettype none

module jst_checker
    import jst_pkg::*;
#(
    parameter int MAX_NEST_DEPTH = MAX_NEST_DEPTH_DEF
) (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic [KIND_W-1:0]  token_kind,
    input wire logic [DEPTH_W-1:0] nest_depth,
    input wire logic [ERR_W-1:0]   error_code,
    input wire logic               doc_done,
    input wire logic               doc_ok
);

    localparam logic [DEPTH_W-1:0] DepthLimit = DEPTH_W'(MAX_NEST_DEPTH);

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // With no result pending, a request can always be taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("request refused with empty result register");

    // A clean document close is only reported on the last byte without error.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && doc_ok |-> doc_done && (error_code == ERR_NONE))
        else $error("doc_ok without clean final byte");

    // Once an error is pending every byte is a skip.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (error_code != ERR_NONE) |-> (token_kind == TK_SKIP))
        else $error("token reported while in error");

    // Depth never passes the configured limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (nest_depth <= DepthLimit))
        else $error("nesting depth beyond limit");

endmodule

bind json_subset_tokenizer jst_checker #(
    .MAX_NEST_DEPTH (MAX_NEST_DEPTH)
) u_jst_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (din.ready),
    .out_valid  (dout.valid),
    .out_ready  (dout.ready),
    .token_kind (dout.token_kind),
    .nest_depth (dout.nest_depth),
    .error_code (dout.error_code),
    .doc_done   (dout.doc_done),
    .doc_ok     (dout.doc_ok)
);

`default_nettype wire
